// ===== rtl/peq_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority event queue package
// Command and result types and the codes shared by the queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package peq_pkg;

	localparam logic       CMD_INSERT   = 1'b0;
	localparam logic       CMD_EXTRACT  = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam logic [3:0] CAP_RESET    = 4'd8;

	typedef struct packed {
		logic        command;
		logic [7:0]  task_id;
		logic [7:0]  priority_req;
		logic [31:0] event_data;
	} peq_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_task_id;
		logic [7:0]  out_priority;
		logic [31:0] out_event_data;
		logic [3:0]  entries_held;
	} peq_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/peq_front.sv =====
// ----------------------------------------------------------------------------
// Priority event queue front end
// Accepts commands and holds them in a two-slot queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module peq_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire peq_pkg::peq_cmd_t cmd,
	output logic                   q_valid,
	output peq_pkg::peq_cmd_t      q_item,
	input  wire logic              q_pop
);

	peq_pkg::peq_cmd_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;

	assign busy    = (count_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign q_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/peq_back.sv =====
// ----------------------------------------------------------------------------
// Priority event queue back end
// Executes inserts and extracts on the entry store and issues one result each.
// ----------------------------------------------------------------------------
`default_nettype none

module peq_back #(
	parameter int QUEUE_DEPTH = 8,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire peq_pkg::peq_cmd_t q_item,
	output logic                   q_pop,
	input  wire logic              cfg_valid,
	input  wire logic [3:0]        cfg_data,
	output logic                   done,
	output peq_pkg::peq_rsp_t      result
);

	localparam int IW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = (CW > 4) ? CW : 4;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;

	logic [7:0]            entry_task     [QUEUE_DEPTH];
	logic [7:0]            entry_priority [QUEUE_DEPTH];
	logic [DATA_WIDTH-1:0] entry_data     [QUEUE_DEPTH];

	logic [1:0]            state_q;
	logic [CW-1:0]         fill_q;
	logic [3:0]            cap_q;
	logic [CW-1:0]         scan_idx_q;
	logic [IW-1:0]         best_idx_q;
	logic [7:0]            best_task_q;
	logic [7:0]            best_prio_q;
	logic [DATA_WIDTH-1:0] best_data_q;
	logic                  done_q;
	peq_pkg::peq_rsp_t     result_q;

	logic                  is_full;
	logic                  do_insert;
	logic                  do_shift;
	logic [63:0]           in_data_ext;
	logic [63:0]           out_data_ext;
	logic [CMPW-1:0]       held_inc;
	logic [CMPW-1:0]       held_dec;
	logic [CMPW-1:0]       held_now;
	logic [IW-1:0]         scan_idx;

	assign q_pop        = (state_q == ST_IDLE) && q_valid;
	assign is_full      = (fill_q >= CW'(QUEUE_DEPTH)) || (CMPW'(fill_q) >= CMPW'(cap_q));
	assign do_insert    = q_pop && (q_item.command == peq_pkg::CMD_INSERT) && !is_full;
	assign do_shift     = (state_q == ST_SHIFT);
	assign in_data_ext  = 64'(q_item.event_data);
	assign out_data_ext = 64'(best_data_q);
	assign held_inc     = CMPW'(fill_q) + CMPW'(1);
	assign held_dec     = CMPW'(fill_q) - CMPW'(1);
	assign held_now     = CMPW'(fill_q);
	assign scan_idx     = scan_idx_q[IW-1:0];
	assign done         = done_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			if (do_insert && (fill_q == CW'(k))) begin
				entry_task[k]     <= q_item.task_id;
				entry_priority[k] <= q_item.priority_req;
				entry_data[k]     <= in_data_ext[DATA_WIDTH-1:0];
			end else if (do_shift && (k < QUEUE_DEPTH - 1) && (IW'(k) >= best_idx_q)) begin
				entry_task[k]     <= entry_task[(k + 1) % QUEUE_DEPTH];
				entry_priority[k] <= entry_priority[(k + 1) % QUEUE_DEPTH];
				entry_data[k]     <= entry_data[(k + 1) % QUEUE_DEPTH];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				best_idx_q  <= '0;
				best_task_q <= entry_task[0];
				best_prio_q <= entry_priority[0];
				best_data_q <= entry_data[0];
			end
			ST_SCAN: begin
				if ((scan_idx_q < fill_q) && (entry_priority[scan_idx] > best_prio_q)) begin
					best_idx_q  <= scan_idx;
					best_task_q <= entry_task[scan_idx];
					best_prio_q <= entry_priority[scan_idx];
					best_data_q <= entry_data[scan_idx];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		result_q.out_task_id    <= '0;
		result_q.out_priority   <= '0;
		result_q.out_event_data <= '0;
		result_q.status         <= peq_pkg::STATUS_OK;
		result_q.entries_held   <= held_now[3:0];
		if (q_pop) begin
			if (q_item.command == peq_pkg::CMD_INSERT) begin
				if (is_full) begin
					result_q.status <= peq_pkg::STATUS_FULL;
				end else begin
					result_q.entries_held <= held_inc[3:0];
				end
			end else if (fill_q == '0) begin
				result_q.status <= peq_pkg::STATUS_EMPTY;
			end
		end else if (do_shift) begin
			result_q.out_task_id    <= best_task_q;
			result_q.out_priority   <= best_prio_q;
			result_q.out_event_data <= out_data_ext[31:0];
			result_q.entries_held   <= held_dec[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			cap_q      <= peq_pkg::CAP_RESET;
			scan_idx_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					scan_idx_q <= CW'(1);
					if (q_pop) begin
						if (q_item.command == peq_pkg::CMD_INSERT) begin
							done_q <= 1'b1;
							if (!is_full) begin
								fill_q <= fill_q + CW'(1);
							end
						end else if (fill_q == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_idx_q < fill_q) begin
						scan_idx_q <= scan_idx_q + CW'(1);
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					fill_q  <= fill_q - CW'(1);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(QUEUE_DEPTH))
		else $error("fill count exceeds queue depth");

	a_shift_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |=> done_q && (result_q.status == peq_pkg::STATUS_OK)
			&& (fill_q == $past(fill_q) - CW'(1)))
		else $error("extract did not issue its result");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (result_q.status == peq_pkg::STATUS_EMPTY)) |-> (fill_q == '0))
		else $error("empty status while entries are held");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_idx_q <= fill_q) && (fill_q != '0)
			&& (CW'(best_idx_q) < fill_q))
		else $error("scan index out of range");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> !done_q || $past(scan_idx_q) >= $past(fill_q))
		else $error("result issued during a scan");

endmodule

`default_nettype wire

// ===== rtl/priority_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// Priority event queue core
// Bounded event queue with highest-priority extract and FIFO order on ties.
//
//   Channel   Signals                          Transfer
//   command   start, busy, cmd                 start high and busy low
//   result    done, result                     done high, one cycle
//   config    cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready high
//
// A command is always registered in the two-slot command queue before the
// back end pops it. An insert, and an extract that finds the queue empty,
// then issue their result from idle. An extract runs the one-entry-per-cycle
// priority scan and then the shift state. Reset clears the fill count and sets
// the capacity to eight; the entry store holds no reset value. The result side
// never stalls, and busy rises only while both command slots are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_event_queue_core #(
	parameter int QUEUE_DEPTH = 8,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire peq_pkg::peq_cmd_t cmd,
	output logic                   done,
	output peq_pkg::peq_rsp_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [3:0]        cfg_data
);

	logic              q_valid;
	logic              q_pop;
	peq_pkg::peq_cmd_t q_item;

	assign cfg_ready = 1'b1;

	peq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	peq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire
